// File: hdl/tcw_pkg.sv
// Package of the text console writer: field widths, character codes,
// request modes, register indexes and the control state type.
// No dependencies; used by the top level and the testbench, not by tcw_ram.
package tcw_pkg;

  // Widths of the stream payload fields.
  localparam int MODE_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int IN_ROW_W  = 5;
  localparam int IN_COL_W  = 7;
  localparam int OUT_COL_W = 7;
  localparam int OUT_ROW_W = 5;
  localparam int ATTR_W    = 8;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;
  localparam logic [CFG_DATA_W-1:0] FG_RESET = 4'd7;
  localparam logic [CFG_DATA_W-1:0] BG_RESET = 4'd0;

  // Control characters and the blank cell character.
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

  // Request modes carried in the input tuser.
  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE = 2'd0,
    MODE_CLEAR = 2'd1,
    MODE_READ  = 2'd2,
    MODE_UNSUP = 2'd3
  } mode_t;

  // Control sequencer states.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EXEC   = 5'b00010,
    S_RDWAIT = 5'b00100,
    S_BLANK  = 5'b01000,
    S_CLEAR  = 5'b10000
  } state_t;

endpackage

// File: hdl/tcw_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/text_console_char_writer.sv
// Top level of the text console writer: request sequencer, cursor, scroll
// pointer and result register around one screen RAM.
// Depends on tcw_pkg and tcw_ram.
//
//  Channel  Direction  Beat contents
//  in_      slave      tdata: char_code, read_row, read_column; tuser: mode
//  out_     master     tdata: cursor_column, cursor_row, cell_char,
//                      cell_attribute, status
//  cfg_     write      cfg_index selects foreground or background colour
//
// A character, an unsupported request or an off-screen read is accepted, then
// executed; an on-screen cell read also waits for the registered RAM read.
// A scroll then blanks the new bottom row, one RAM write per cell; rows are
// mapped through a rotating top-row pointer, so no rows are copied. A clear
// writes every cell, one RAM write per cell. After reset a clearing pass runs
// with in_tready low. The result register lets the next beat be accepted
// while one result is still waiting on out_tready.
module text_console_char_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Request stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] char_code, [12:8] read_row, [19:13] read_column
  input  logic [tcw_pkg::IN_DATA_W-1:0]       in_tdata,
  // [1:0] mode
  input  logic [tcw_pkg::MODE_W-1:0]          in_tuser,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [6:0] cursor_column, [11:7] cursor_row, [19:12] cell_char,
  // [27:20] cell_attribute, [28] status
  output logic [tcw_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Configuration writes.
  input  logic                                cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import tcw_pkg::*;

  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CELLS  = ROWS * COLS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ATTR_W-1:0] RESET_ATTR = {BG_RESET, FG_RESET};

  // Registers.
  state_t                  state_r, state_nxt;
  logic                    pend_r, pend_nxt;
  logic                    out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0]   out_tdata_r, out_tdata_nxt;
  logic [COL_W-1:0]        cursor_col_r, cursor_col_nxt;
  logic [ROW_W-1:0]        cursor_row_r, cursor_row_nxt;
  logic [ROW_W-1:0]        top_r, top_nxt;
  logic [CFG_DATA_W-1:0]   fg_r, fg_nxt;
  logic [CFG_DATA_W-1:0]   bg_r, bg_nxt;
  logic [ATTR_W-1:0]       fill_attr_r, fill_attr_nxt;
  logic [ADDR_W-1:0]       clr_addr_r, clr_addr_nxt;
  logic                    clr_report_r, clr_report_nxt;
  logic [COL_W-1:0]        blank_col_r, blank_col_nxt;
  logic [ADDR_W-1:0]       blank_base_r, blank_base_nxt;
  mode_t                   item_mode_r, item_mode_nxt;
  logic [CHAR_W-1:0]       item_char_r, item_char_nxt;
  logic [IN_ROW_W-1:0]     item_rrow_r, item_rrow_nxt;
  logic [IN_COL_W-1:0]     item_rcol_r, item_rcol_nxt;
  logic [CHAR_W-1:0]       res_char_r, res_char_nxt;
  logic [ATTR_W-1:0]       res_attr_r, res_attr_nxt;
  logic                    res_status_r, res_status_nxt;

  // Screen RAM ports.
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [CELL_W-1:0]       mem_wdata;
  logic                    mem_re;
  logic [ADDR_W-1:0]       mem_raddr;
  logic [CELL_W-1:0]       mem_rdata;

  // Execute-stage helpers.
  logic                    out_free, load_out, in_accept;
  logic [ATTR_W-1:0]       cur_attr;
  logic [ROW_W-1:0]        row_sel, prow;
  logic [COL_W-1:0]        col_sel;
  logic [ROW_W:0]          prow_sum;
  logic [ADDR_W-1:0]       exec_addr, top_base;
  logic                    rd_in_range;
  logic                    is_nl, is_cr, is_bs, is_print;
  logic                    col_last, row_last, wrap, scroll;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Handshakes: a finished result moves to the output register from idle.
  assign out_free   = !out_tvalid_r || out_tready;
  assign load_out   = (state_r == S_IDLE) && pend_r && out_free;
  assign in_tready  = (state_r == S_IDLE) && (!pend_r || out_free);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign cur_attr = {bg_r, fg_r};

  // Cell address of the cursor or of the requested cell, through the top-row pointer.
  assign row_sel  = (item_mode_r == MODE_READ) ? ROW_W'(item_rrow_r) : cursor_row_r;
  assign col_sel  = (item_mode_r == MODE_READ) ? COL_W'(item_rcol_r) : cursor_col_r;
  assign prow_sum = {1'b0, top_r} + {1'b0, row_sel};
  assign prow     = (prow_sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(prow_sum - (ROW_W+1)'(ROWS))
                                                   : ROW_W'(prow_sum);
  assign exec_addr = ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLS)) + ADDR_W'(col_sel);
  assign top_base  = ADDR_W'(ADDR_W'(top_r) * ADDR_W'(COLS));
  assign rd_in_range = (32'(item_rrow_r) < ROWS) && (32'(item_rcol_r) < COLS);

  // Character decode and cursor movement.
  assign is_nl    = (item_char_r == CH_NEWLINE);
  assign is_cr    = (item_char_r == CH_RETURN);
  assign is_bs    = (item_char_r == CH_BACKSPACE);
  assign is_print = !is_nl && !is_cr && !is_bs;
  assign col_last = (cursor_col_r == COL_W'(COLS - 1));
  assign row_last = (cursor_row_r == ROW_W'(ROWS - 1));
  assign wrap     = is_nl || (is_print && col_last);
  assign scroll   = wrap && row_last;

  // Sequencer and next-state logic.
  always_comb begin
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    cursor_col_nxt = cursor_col_r;
    cursor_row_nxt = cursor_row_r;
    top_nxt        = top_r;
    fg_nxt         = fg_r;
    bg_nxt         = bg_r;
    fill_attr_nxt  = fill_attr_r;
    clr_addr_nxt   = clr_addr_r;
    clr_report_nxt = clr_report_r;
    blank_col_nxt  = blank_col_r;
    blank_base_nxt = blank_base_r;
    item_mode_nxt  = item_mode_r;
    item_char_nxt  = item_char_r;
    item_rrow_nxt  = item_rrow_r;
    item_rcol_nxt  = item_rcol_r;
    res_char_nxt   = res_char_r;
    res_attr_nxt   = res_attr_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = exec_addr;
    mem_wdata      = {cur_attr, item_char_r};
    mem_re         = 1'b0;
    mem_raddr      = exec_addr;

    // Configuration writes; indexes beyond the list are ignored.
    if (cfg_we) begin
      if (cfg_index == CFG_FOREGROUND) begin
        fg_nxt = cfg_data;
      end else if (cfg_index == CFG_BACKGROUND) begin
        bg_nxt = cfg_data;
      end
    end

    // Result register.
    if (load_out) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = OUT_DATA_W'({res_status_r, res_attr_r, res_char_r,
                                    OUT_ROW_W'(cursor_row_r), OUT_COL_W'(cursor_col_r)});
      pend_nxt       = 1'b0;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          item_mode_nxt = mode_t'(in_tuser);
          item_char_nxt = in_tdata[7:0];
          item_rrow_nxt = in_tdata[12:8];
          item_rcol_nxt = in_tdata[19:13];
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        res_char_nxt   = '0;
        res_attr_nxt   = '0;
        res_status_nxt = 1'b0;
        unique case (item_mode_r)
          MODE_WRITE: begin
            mem_we = is_print;
            if (is_nl || is_cr || wrap) begin
              cursor_col_nxt = '0;
            end else if (is_bs) begin
              if (cursor_col_r != '0) begin
                cursor_col_nxt = cursor_col_r - COL_W'(1);
              end
            end else begin
              cursor_col_nxt = cursor_col_r + COL_W'(1);
            end
            if (wrap && !row_last) begin
              cursor_row_nxt = cursor_row_r + ROW_W'(1);
            end
            if (scroll) begin
              // The old top row becomes the new bottom row and is blanked.
              top_nxt        = row_last && (top_r == ROW_W'(ROWS - 1)) ? '0
                                                                       : top_r + ROW_W'(1);
              blank_base_nxt = top_base;
              blank_col_nxt  = '0;
              fill_attr_nxt  = cur_attr;
              state_nxt      = S_BLANK;
            end else begin
              pend_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          MODE_CLEAR: begin
            cursor_col_nxt = '0;
            cursor_row_nxt = '0;
            top_nxt        = '0;
            clr_addr_nxt   = '0;
            clr_report_nxt = 1'b1;
            fill_attr_nxt  = cur_attr;
            state_nxt      = S_CLEAR;
          end
          MODE_READ: begin
            if (rd_in_range) begin
              mem_re    = 1'b1;
              state_nxt = S_RDWAIT;
            end else begin
              pend_nxt  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
          MODE_UNSUP: begin
            res_status_nxt = 1'b1;
            pend_nxt       = 1'b1;
            state_nxt      = S_IDLE;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_RDWAIT: begin
        res_char_nxt = mem_rdata[CHAR_W-1:0];
        res_attr_nxt = mem_rdata[CELL_W-1:CHAR_W];
        pend_nxt     = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_BLANK: begin
        mem_we        = 1'b1;
        mem_waddr     = blank_base_r + ADDR_W'(blank_col_r);
        mem_wdata     = {fill_attr_r, CH_SPACE};
        blank_col_nxt = blank_col_r + COL_W'(1);
        if (blank_col_r == COL_W'(COLS - 1)) begin
          pend_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = {fill_attr_r, CH_SPACE};
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(CELLS - 1)) begin
          pend_nxt  = clr_report_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers; reset starts the clearing pass with the reset colours.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      top_r        <= '0;
      fg_r         <= FG_RESET;
      bg_r         <= BG_RESET;
      fill_attr_r  <= RESET_ATTR;
      clr_addr_r   <= '0;
      clr_report_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      cursor_col_r <= cursor_col_nxt;
      cursor_row_r <= cursor_row_nxt;
      top_r        <= top_nxt;
      fg_r         <= fg_nxt;
      bg_r         <= bg_nxt;
      fill_attr_r  <= fill_attr_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_report_r <= clr_report_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_tdata_r  <= out_tdata_nxt;
    blank_col_r  <= blank_col_nxt;
    blank_base_r <= blank_base_nxt;
    item_mode_r  <= item_mode_nxt;
    item_char_r  <= item_char_nxt;
    item_rrow_r  <= item_rrow_nxt;
    item_rcol_r  <= item_rcol_nxt;
    res_char_r   <= res_char_nxt;
    res_attr_r   <= res_attr_nxt;
    res_status_r <= res_status_nxt;
  end

`ifndef NO_ASSERTIONS
  // An accepted beat is executed in the following cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_EXEC)
    else $error("accepted beat not executed next cycle");

  // A finished result only waits while the sequencer is idle.
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == S_IDLE)
    else $error("result pending outside idle");

  // The cursor and the top-row pointer stay on the screen.
  a_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(cursor_row_r) < ROWS) && (32'(cursor_col_r) < COLS) && (32'(top_r) < ROWS))
    else $error("cursor or top row off screen");

  // Blanking follows a scroll, so the cursor sits on the bottom row.
  a_blank_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_BLANK |-> cursor_row_r == ROW_W'(ROWS - 1))
    else $error("row blanked while cursor not on bottom row");

  // The screen is written only while executing, blanking or clearing.
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_EXEC) || (state_r == S_BLANK) || (state_r == S_CLEAR))
    else $error("screen written in wrong state");
`endif

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the text console character writer: request beats are
// scored against an in-house screen, cursor and colour predictor.
// Depends on tcw_pkg and text_console_char_writer.
module tb;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = ROWS * COLS;
  localparam int IN_FIELDS_W = CHAR_W + IN_ROW_W + IN_COL_W;
  localparam int OUT_FIELDS_W = OUT_COL_W + OUT_ROW_W + CHAR_W + ATTR_W + 1;
  // Long enough for a full clear walk or a scroll blank to finish.
  localparam int SETTLE_CYCLES = CELLS + COLS;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 10 * CELLS;
  // Register indexes past the end of the register list; writes to them are ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    mode_t                 mode;
    logic [CHAR_W-1:0]     char_code;
    logic [IN_ROW_W-1:0]   read_row;
    logic [IN_COL_W-1:0]   read_column;
  } console_req_t;

  // Laid out as the result beat, lowest field last.
  typedef struct packed {
    logic [OUT_DATA_W-OUT_FIELDS_W-1:0] pad;
    logic                               status;
    logic [ATTR_W-1:0]                  cell_attribute;
    logic [CHAR_W-1:0]                  cell_char;
    logic [OUT_ROW_W-1:0]               cursor_row;
    logic [OUT_COL_W-1:0]               cursor_column;
  } console_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [MODE_W-1:0]     in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predicted screen, cursor and colours.
  logic [CELL_W-1:0]     shadow_screen [CELLS];
  int                    cur_col;
  int                    cur_row;
  logic [CFG_DATA_W-1:0] fg_colour;
  logic [CFG_DATA_W-1:0] bg_colour;
  console_result_t       pending_results [$];

  int mismatches = 0;
  int beats_checked = 0;
  int chars_sent = 0;
  int reads_sent = 0;
  int clears_sent = 0;
  int unsup_sent = 0;
  int scrolls = 0;
  int colour_settings = 0;
  int quiet_cycles = 0;
  int burst_left = 1;
  bit steady_sender = 1'b0;
  bit hold_request = 1'b0;

  text_console_char_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [ATTR_W-1:0] current_attr();
    return {bg_colour, fg_colour};
  endfunction

  // Fill every cell with a space in the current colours and home the cursor.
  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) shadow_screen[i] = {current_attr(), CH_SPACE};
    cur_col = 0;
    cur_row = 0;
  endfunction

  // Apply one request to the predicted console and return the result it causes.
  function automatic console_result_t console_apply(console_req_t rq);
    console_result_t r;
    logic [CELL_W-1:0] scr_word;
    r = '0;
    case (rq.mode)
      MODE_WRITE: begin
        chars_sent++;
        if (rq.char_code == CH_NEWLINE) begin
          cur_col = 0;
          cur_row++;
        end else if (rq.char_code == CH_RETURN) begin
          cur_col = 0;
        end else if (rq.char_code == CH_BACKSPACE) begin
          if (cur_col > 0) cur_col--;
        end else begin
          shadow_screen[cur_row * COLS + cur_col] = {current_attr(), rq.char_code};
          cur_col++;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_row++;
        end
        // Past the bottom row: scroll up one row and blank the new bottom row.
        if (cur_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
          for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = {current_attr(), CH_SPACE};
          cur_row = ROWS - 1;
          scrolls++;
        end
      end
      MODE_CLEAR: begin
        clears_sent++;
        blank_screen();
      end
      MODE_READ: begin
        reads_sent++;
        if (rq.read_row < ROWS && rq.read_column < COLS) begin
          scr_word = shadow_screen[rq.read_row * COLS + rq.read_column];
          r.cell_char = scr_word[CHAR_W-1:0];
          r.cell_attribute = scr_word[CELL_W-1:CHAR_W];
        end
      end
      default: begin
        unsup_sent++;
        r.status = 1'b1;
      end
    endcase
    r.cursor_column = cur_col[OUT_COL_W-1:0];
    r.cursor_row = cur_row[OUT_ROW_W-1:0];
    return r;
  endfunction

  function automatic console_req_t make_req(mode_t m, logic [CHAR_W-1:0] c,
                                            logic [IN_ROW_W-1:0] row,
                                            logic [IN_COL_W-1:0] col);
    console_req_t rq;
    rq.mode = m;
    rq.char_code = c;
    rq.read_row = row;
    rq.read_column = col;
    return rq;
  endfunction

  // Random request: mostly characters, with the share of newlines and clears chosen
  // by the caller. Fields a mode does not use are random as well.
  function automatic console_req_t random_request(int newline_pct, int clear_pct);
    console_req_t rq;
    int pick;
    rq.mode = MODE_WRITE;
    rq.char_code = CHAR_W'($urandom_range(0, 255));
    rq.read_row = IN_ROW_W'($urandom_range(0, 31));
    rq.read_column = IN_COL_W'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < clear_pct) begin
      rq.mode = MODE_CLEAR;
    end else if (pick < clear_pct + 5) begin
      rq.mode = MODE_UNSUP;
    end else if (pick < clear_pct + 25) begin
      rq.mode = MODE_READ;
      if ($urandom_range(0, 99) < 85) begin
        rq.read_row = IN_ROW_W'($urandom_range(0, ROWS - 1));
        rq.read_column = IN_COL_W'($urandom_range(0, COLS - 1));
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < newline_pct) rq.char_code = CH_NEWLINE;
      else if (pick < newline_pct + 2) rq.char_code = CH_RETURN;
      else if (pick < newline_pct + 6) rq.char_code = CH_BACKSPACE;
    end
    return rq;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  // Offer one request beat and record its prediction once accepted. The sender
  // works in bursts; unless steady_sender is set, tvalid drops for a random gap at the end of a burst.
  task automatic send_request(console_req_t rq);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= rq.mode;
    in_tdata <= {{(IN_DATA_W - IN_FIELDS_W){1'b0}}, rq.read_column, rq.read_row, rq.char_code};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(console_apply(rq));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !steady_sender) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left == 0) burst_left = $urandom_range(1, 40);
  endtask

  task automatic run_requests(int count, int newline_pct, int clear_pct);
    repeat (count) send_request(random_request(newline_pct, clear_pct));
  endtask

  // Stop offering, wait for every pending result, then let any blanking walk finish.
  task automatic drain_and_settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FOREGROUND) fg_colour = val;
    else if (idx == CFG_BACKGROUND) bg_colour = val;
  endtask

  task automatic set_colours(logic [CFG_DATA_W-1:0] fg, logic [CFG_DATA_W-1:0] bg);
    drain_and_settle();
    write_reg(CFG_FOREGROUND, fg);
    write_reg(CFG_BACKGROUND, bg);
    colour_settings++;
  endtask

  // Field extremes, every mode and the control characters, straight after reset.
  task automatic test_directed_edges();
    // Reset contents at both corners, then reads that fall off the screen.
    send_request(make_req(MODE_READ, 8'h00, 5'd0, 7'd0));
    send_request(make_req(MODE_READ, 8'hFF, IN_ROW_W'(ROWS - 1), IN_COL_W'(COLS - 1)));
    send_request(make_req(MODE_READ, 8'h00, IN_ROW_W'(ROWS), 7'd0));
    send_request(make_req(MODE_READ, 8'h00, 5'd0, IN_COL_W'(COLS)));
    send_request(make_req(MODE_READ, 8'h00, 5'h1F, 7'h7F));
    // Character extremes, backspace mid-row and at column 0, return and newline.
    send_request(make_req(MODE_WRITE, 8'h00, 5'h1F, 7'h7F));
    send_request(make_req(MODE_WRITE, 8'hFF, 5'd0, 7'd0));
    send_request(make_req(MODE_WRITE, 8'h41, 5'd0, 7'd0));
    send_request(make_req(MODE_WRITE, CH_BACKSPACE, 5'd0, 7'd0));
    send_request(make_req(MODE_WRITE, CH_RETURN, 5'd0, 7'd0));
    send_request(make_req(MODE_WRITE, CH_BACKSPACE, 5'd0, 7'd0));
    send_request(make_req(MODE_WRITE, 8'h5A, 5'd0, 7'd0));
    send_request(make_req(MODE_WRITE, CH_NEWLINE, 5'd0, 7'd0));
    send_request(make_req(MODE_READ, 8'h00, 5'd0, 7'd0));
    send_request(make_req(MODE_READ, 8'h00, 5'd0, 7'd1));
    send_request(make_req(MODE_READ, 8'h00, 5'd0, 7'd2));
    // Unsupported mode with all field bits high and low, then a clear.
    send_request(make_req(MODE_UNSUP, 8'hFF, 5'h1F, 7'h7F));
    send_request(make_req(MODE_UNSUP, 8'h00, 5'd0, 7'd0));
    send_request(make_req(MODE_CLEAR, 8'hFF, 5'h1F, 7'h7F));
    send_request(make_req(MODE_READ, 8'h00, 5'd0, 7'd0));
    send_request(make_req(MODE_READ, 8'h00, 5'd1, 7'd0));
  endtask

  // Colour extremes and random colours, with writes to the unused indexes.
  task automatic test_colour_settings();
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: set_colours(4'h0, 4'h0);
        1: set_colours(4'hF, 4'hF);
        2: set_colours(4'hF, 4'h0);
        3: set_colours(4'h0, 4'hF);
        default: set_colours(CFG_DATA_W'($urandom_range(0, 15)),
                             CFG_DATA_W'($urandom_range(0, 15)));
      endcase
      if (k >= 4) begin
        write_reg(CFG_SPARE_2, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(CFG_SPARE_3, CFG_DATA_W'($urandom_range(0, 15)));
      end
      run_requests(120, 15, 2);
    end
  endtask

  // Newline-heavy text with no clears, so the screen scrolls many times.
  task automatic test_scroll();
    set_colours(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)));
    run_requests(300, 60, 0);
  endtask

  // Long lines without newlines: wraps, many of them on the bottom row.
  task automatic test_line_wrap();
    set_colours(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)));
    run_requests(400, 0, 0);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    hold_request = 1'b1;
    steady_sender = 1'b1;
    run_requests(80, 15, 0);
    steady_sender = 1'b0;
  endtask

  task automatic test_random_mix();
    set_colours(CFG_DATA_W'($urandom_range(0, 15)), CFG_DATA_W'($urandom_range(0, 15)));
    run_requests(300, 15, 1);
  endtask

  // Receiver: runs of always-ready, random and mostly-stalled patterns, plus the
  // long hold-off when one is requested.
  initial begin : result_sink
    int run_left;
    int stall_kind;
    int hold_left;
    run_left = 0;
    stall_kind = 0;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 48);
          stall_kind = $urandom_range(0, 3);
        end
        run_left--;
        case (stall_kind)
          0, 1: out_tready <= 1'b1;
          2: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Score each result beat against the oldest prediction; count idle cycles.
  always @(posedge clk) begin : result_check
    console_result_t want;
    console_result_t got;
    if (out_tvalid && out_tready) begin
      beats_checked++;
      got = console_result_t'(out_tdata);
      if (pending_results.size() == 0) begin
        mismatches++;
        $error("result beat %h arrived with no request outstanding", out_tdata);
      end else begin
        want = pending_results.pop_front();
        check_field("cursor_column", 8'(want.cursor_column), 8'(got.cursor_column));
        check_field("cursor_row", 8'(want.cursor_row), 8'(got.cursor_row));
        check_field("cell_char", want.cell_char, got.cell_char);
        check_field("cell_attribute", want.cell_attribute, got.cell_attribute);
        check_field("status", 8'(want.status), 8'(got.status));
      end
    end
    if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
    else quiet_cycles++;
  end

  // Ends the run if no beat moves on either side for too long.
  initial begin : watchdog
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb: errors");
    $finish;
  end

  initial begin : main
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fg_colour = FG_RESET;
    bg_colour = BG_RESET;
    blank_screen();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_edges();
    test_colour_settings();
    test_scroll();
    test_line_wrap();
    test_backpressure();
    test_random_mix();
    drain_and_settle();

    if (pending_results.size() != 0) begin
      mismatches++;
      $error("%0d predicted results never arrived", pending_results.size());
    end
    $display("Covered %0d characters, %0d reads, %0d clears and %0d unsupported requests.",
             chars_sent, reads_sent, clears_sent, unsup_sent);
    $display("%0d scrolls, %0d colour settings, %0d result beats checked, %0d mismatches.",
             scrolls, colour_settings, beats_checked, mismatches);
    if (mismatches == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
